// File: src/h264fua_pkg.sv
// Shared types and constants for the H.264 FU-A to Annex B converter.
// No dependencies; every module of the block refers to this package by scoped name.
package h264fua_pkg;

  localparam logic [7:0] TYPE_MASK  = 8'b0001_1111;
  localparam logic [7:0] START_BIT  = 8'b1000_0000;
  localparam logic [7:0] NRI_MASK   = 8'b1110_0000;
  localparam logic [4:0] FU_A_TYPE  = 5'd28;
  localparam logic [7:0] START_ZERO = 8'h00;
  localparam logic [7:0] START_ONE  = 8'h01;

  localparam int IDX_W = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       code_start;
  } out_item_t;

  typedef enum logic [2:0] {
    POS_FIRST  = 3'b001,
    POS_SECOND = 3'b010,
    POS_REST   = 3'b100
  } pos_t;

  typedef enum logic [1:0] {
    CMD_PASS     = 2'd0,
    CMD_FU_START = 2'd1,
    CMD_FULL     = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] first;
    logic [7:0] second;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_wr_t;

  function automatic logic [IDX_W-1:0] cmd_len(cmd_kind_t kind);
    logic [IDX_W-1:0] len;
    unique case (kind)
      CMD_FU_START: len = IDX_W'(4);
      CMD_FULL:     len = IDX_W'(5);
      default:      len = IDX_W'(1);
    endcase
    return len;
  endfunction

endpackage

// File: src/h264fua_front.sv
// Front end: tracks the byte position in a packet, holds byte 0, and turns
// each payload byte into at most one emit command. Uses h264fua_pkg.
module h264fua_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  h264fua_pkg::in_item_t packet_byte,
  output h264fua_pkg::cmd_wr_t  cmd_wr
);

  h264fua_pkg::pos_t pos, pos_next;
  logic [7:0]        held_first_byte, held_first_byte_next;

  always_comb begin
    pos_next             = pos;
    held_first_byte_next = held_first_byte;
    cmd_wr.valid         = 1'b0;
    cmd_wr.cmd.kind      = h264fua_pkg::CMD_PASS;
    cmd_wr.cmd.first     = held_first_byte;
    cmd_wr.cmd.second    = packet_byte.data_byte;
    if (accept) begin
      unique case (pos)
        h264fua_pkg::POS_FIRST: begin
          held_first_byte_next = packet_byte.data_byte;
          pos_next             = h264fua_pkg::POS_SECOND;
        end
        h264fua_pkg::POS_SECOND: begin
          if (held_first_byte[4:0] == h264fua_pkg::FU_A_TYPE) begin
            if ((packet_byte.data_byte & h264fua_pkg::START_BIT) != 8'd0) begin
              cmd_wr.valid     = 1'b1;
              cmd_wr.cmd.kind  = h264fua_pkg::CMD_FU_START;
              cmd_wr.cmd.first = (held_first_byte & h264fua_pkg::NRI_MASK) |
                                 (packet_byte.data_byte & h264fua_pkg::TYPE_MASK);
            end
          end else begin
            cmd_wr.valid    = 1'b1;
            cmd_wr.cmd.kind = h264fua_pkg::CMD_FULL;
          end
          pos_next = h264fua_pkg::POS_REST;
        end
        default: begin
          cmd_wr.valid = 1'b1;
          pos_next     = h264fua_pkg::POS_REST;
        end
      endcase
      if (packet_byte.packet_end) begin
        pos_next = h264fua_pkg::POS_FIRST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= h264fua_pkg::POS_FIRST;
    end else begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    held_first_byte <= held_first_byte_next;
  end

endmodule

// File: src/h264fua_cmd_fifo.sv
// Command queue between the front end and the output sequencer.
// Register storage of DEPTH commands; uses h264fua_pkg.
module h264fua_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  h264fua_pkg::cmd_wr_t cmd_wr,
  input  logic                 rd_en,
  output h264fua_pkg::cmd_t    head,
  output logic                 full,
  output logic                 empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  h264fua_pkg::cmd_t mem [DEPTH];
  logic [PTR_W-1:0]  wptr, rptr;
  logic [CNT_W-1:0]  count;
  logic              wr_go, rd_go;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign wr_go = cmd_wr.valid && !full;
  assign rd_go = rd_en && !empty;
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_go) begin
      mem[wptr] <= cmd_wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_go) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (rd_go) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (wr_go && !rd_go) begin
        count <= count + CNT_W'(1);
      end else if (rd_go && !wr_go) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("command queue count out of range");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (wr_go && !rd_go) |=> (count == $past(count) + CNT_W'(1)))
    else $error("command queue count did not advance on write");

endmodule

// File: src/h264fua_back.sv
// Output sequencer: expands the command at the queue head into one to five
// stream bytes and retires it when its last byte is taken. Uses h264fua_pkg.
module h264fua_back (
  input  logic                   clk,
  input  logic                   rst,
  input  h264fua_pkg::cmd_t      head,
  input  logic                   head_empty,
  input  logic                   pop,
  output logic                   head_done,
  output h264fua_pkg::out_item_t stream_byte
);

  logic [h264fua_pkg::IDX_W-1:0] idx, len;
  logic                          take;

  assign len                    = h264fua_pkg::cmd_len(head.kind);
  assign take                   = pop && !head_empty;
  assign stream_byte.run_last   = (idx == len - h264fua_pkg::IDX_W'(1));
  assign stream_byte.code_start = (head.kind != h264fua_pkg::CMD_PASS) &&
                                  (idx == '0);
  assign head_done              = take && stream_byte.run_last;

  always_comb begin
    if (head.kind == h264fua_pkg::CMD_PASS) begin
      stream_byte.out_byte = head.second;
    end else begin
      case (idx)
        3'd0, 3'd1: stream_byte.out_byte = h264fua_pkg::START_ZERO;
        3'd2:       stream_byte.out_byte = h264fua_pkg::START_ONE;
        3'd3:       stream_byte.out_byte = head.first;
        default:    stream_byte.out_byte = head.second;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (head_done) begin
      idx <= '0;
    end else if (take) begin
      idx <= idx + h264fua_pkg::IDX_W'(1);
    end
  end

  a_idx_in_cmd: assert property (@(posedge clk) disable iff (rst)
    !head_empty |-> (idx < len))
    else $error("sequencer index beyond command length");

  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    head_empty |-> (idx == '0))
    else $error("sequencer index not cleared while queue is empty");

  a_idx_restart: assert property (@(posedge clk) disable iff (rst)
    head_done |=> (idx == '0))
    else $error("sequencer index not cleared after retiring a command");

endmodule

// File: src/h264_rtp_fu_a_depacketizer.sv
// Top level of the H.264 RTP payload to Annex B converter.
// Instantiates h264fua_front, h264fua_cmd_fifo and h264fua_back; uses h264fua_pkg.
//
// Payload bytes enter one per cycle (push while full is low) with packet_end on the
// last byte of each packet. Each byte becomes at most one command in a queue of
// DEPTH entries (2 or more); the output sequencer expands a command into one stream
// byte for a plain payload byte, four bytes (start code plus rebuilt NAL header) for
// an FU-A start fragment, or five bytes (start code, byte 0, byte 1) for the head of
// a packet that is not FU-A. The output side delivers one byte per cycle while pop
// is high, so input throughput is one byte per cycle except while the queue refills
// after packet heads, which expand into extra output bytes. A result can be taken the
// cycle after its byte was accepted. Bytes 0 and 1 of a packet never produce output
// at once: byte 0 is held until byte 1 arrives, and one-byte packets are dropped.
module h264_rtp_fu_a_depacketizer #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  h264fua_pkg::in_item_t  packet_byte,
  output logic                   empty,
  input  logic                   pop,
  output h264fua_pkg::out_item_t stream_byte
);

  h264fua_pkg::cmd_wr_t cmd_wr;
  h264fua_pkg::cmd_t    head;
  logic                 head_done;
  logic                 accept;

  assign accept = push && !full;

  h264fua_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .packet_byte (packet_byte),
    .cmd_wr      (cmd_wr)
  );

  h264fua_cmd_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .cmd_wr (cmd_wr),
    .rd_en  (head_done),
    .head   (head),
    .full   (full),
    .empty  (empty)
  );

  h264fua_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_empty  (empty),
    .pop         (pop),
    .head_done   (head_done),
    .stream_byte (stream_byte)
  );

endmodule

// File: verif/tb_h264_rtp_fu_a_depacketizer.sv
// Testbench for h264_rtp_fu_a_depacketizer: feeds RTP payload bytes and checks the
// Annex B stream against an in-bench predictor kept in a small scoreboard class.
// Depends on h264fua_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_h264_rtp_fu_a_depacketizer;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 40;

  class annexb_scoreboard;
    h264fua_pkg::pos_t       position;
    logic [7:0]              held_first;
    h264fua_pkg::out_item_t  stream_q[$];
    int                      errors;

    function new();
      position   = h264fua_pkg::POS_FIRST;
      held_first = '0;
      errors     = 0;
    endfunction

    function void put_byte(logic [7:0] b, logic code);
      h264fua_pkg::out_item_t r;
      r.out_byte   = b;
      r.run_last   = 1'b0;
      r.code_start = code;
      stream_q = {stream_q, r};
    endfunction

    function void put_start_code();
      put_byte(h264fua_pkg::START_ZERO, 1'b1);
      put_byte(h264fua_pkg::START_ZERO, 1'b0);
      put_byte(h264fua_pkg::START_ONE, 1'b0);
    endfunction

    function void note_byte(h264fua_pkg::in_item_t it);
      int prior_size;
      prior_size = stream_q.size();
      case (position)
        h264fua_pkg::POS_FIRST: begin
          held_first = it.data_byte;
          position   = h264fua_pkg::POS_SECOND;
        end
        h264fua_pkg::POS_SECOND: begin
          if (held_first[4:0] == h264fua_pkg::FU_A_TYPE) begin
            if ((it.data_byte & h264fua_pkg::START_BIT) != 8'h00) begin
              put_start_code();
              put_byte((held_first & h264fua_pkg::NRI_MASK) |
                       (it.data_byte & h264fua_pkg::TYPE_MASK), 1'b0);
            end
          end else begin
            put_start_code();
            put_byte(held_first, 1'b0);
            put_byte(it.data_byte, 1'b0);
          end
          position = h264fua_pkg::POS_REST;
        end
        default: begin
          put_byte(it.data_byte, 1'b0);
          position = h264fua_pkg::POS_REST;
        end
      endcase
      if (stream_q.size() > prior_size)
        stream_q[stream_q.size() - 1].run_last = 1'b1;
      if (it.packet_end)
        position = h264fua_pkg::POS_FIRST;
    endfunction

    function void check_byte(h264fua_pkg::out_item_t got);
      h264fua_pkg::out_item_t want;
      if (stream_q.size() == 0) begin
        $error("unexpected output byte %h", got.out_byte);
        errors++;
        return;
      end
      want = stream_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %b, got %b", want.run_last, got.run_last);
        errors++;
      end
      if (got.code_start !== want.code_start) begin
        $error("code_start: expected %b, got %b", want.code_start, got.code_start);
        errors++;
      end
    endfunction

    function int pending();
      return stream_q.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   push;
  logic                   full;
  h264fua_pkg::in_item_t  packet_byte;
  logic                   empty;
  logic                   pop;
  h264fua_pkg::out_item_t stream_byte;

  annexb_scoreboard sb;
  bit idling;
  int stall_left;

  h264_rtp_fu_a_depacketizer dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .packet_byte (packet_byte),
    .empty       (empty),
    .pop         (pop),
    .stream_byte (stream_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  task automatic send_byte(logic [7:0] b, logic last);
    h264fua_pkg::in_item_t it;
    int                    gap;
    it.data_byte  = b;
    it.packet_end = last;
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push        <= 1'b1;
    packet_byte <= it;
    do @(posedge clk); while (full !== 1'b0);
    sb.note_byte(it);
  endtask

  task automatic send_random_packet(output int sent);
    logic [7:0] first;
    logic [7:0] second;
    int         len;
    int         kind;
    kind = $urandom_range(0, 9);
    len  = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 8);
    if (kind < 6) begin
      first  = {3'($urandom_range(0, 7)), h264fua_pkg::FU_A_TYPE};
      second = 8'($urandom_range(0, 255));
      second[7] = ($urandom_range(0, 3) != 0);
    end else begin
      first  = 8'($urandom_range(0, 255));
      second = 8'($urandom_range(0, 255));
    end
    if (kind == 9)
      len = $urandom_range(1, 3);
    send_byte(first, len == 1);
    if (len > 1)
      send_byte(second, len == 2);
    for (int i = 2; i < len; i++)
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    sent = len;
  endtask

  initial begin
    pop        <= 1'b0;
    stall_left = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (pop && empty === 1'b0)
        sb.check_byte(stream_byte);
      if (idling && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 13);
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int total;
    int sent;
    int waited;
    sb          = new();
    idling      = 1'b1;
    rst         <= 1'b1;
    push        <= 1'b0;
    packet_byte <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // one-byte packet, dropped
    send_byte(8'h7C, 1'b1);
    // FU-A start fragment
    send_byte(8'hFC, 1'b0);
    send_byte(8'h85, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    // FU-A continuation, end bit set
    send_byte(8'h1C, 1'b0);
    send_byte(8'h45, 1'b0);
    send_byte(8'hAA, 1'b1);
    // single NAL unit packet, then a two-byte packet of NAL type 0
    send_byte(8'h67, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // two-byte FU-A start
    send_byte(8'h1C, 1'b0);
    send_byte(8'h9F, 1'b1);
    // STAP-A passes whole, then a two-byte FU-A start
    send_byte(8'h18, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h10, 1'b1);
    send_byte(8'hFC, 1'b0);
    send_byte(8'h80, 1'b1);

    total = 0;
    while (total < 130) begin
      if (total >= 100)
        idling = 1'b0;
      send_random_packet(sent);
      total += sent;
    end
    push <= 1'b0;

    waited = 0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      if (sb.pending() != 0)
        $error("%0d expected output bytes never arrived", sb.pending());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
